### rtl/core/moc_pkg.sv
// Shared constants, widths and types for the module occupancy classifier.
// Used by every module under rtl/core; depends on nothing else.
package moc_pkg;

    // Detector geometry and output cap
    localparam int NUM_LAYERS        = 34;
    localparam int MODULES_PER_LAYER = 7;
    localparam int MAX_HEAVY_ITEMS   = 63;
    localparam int TOTAL_MODULES     = NUM_LAYERS * MODULES_PER_LAYER;

    // Counter store geometry
    localparam int ADDR_W  = (TOTAL_MODULES > 1) ? $clog2(TOTAL_MODULES) : 1;
    localparam int SCAN_W  = $clog2(TOTAL_MODULES + 1);
    localparam int COUNT_W = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    // Field widths of the streams
    localparam int LAYER_W  = 6;
    localparam int MODREQ_W = 3;
    localparam int IDX_W    = 8;
    localparam int TALLY_W  = 8;
    localparam int EMIT_W   = 6;
    localparam int HIT_W    = 12;

    // Heavy threshold: more than this many hits makes a module heavy
    localparam logic [COUNT_W-1:0] HEAVY_LIMIT = 9'd2;

    // Result kinds
    localparam logic KIND_HEAVY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Control state, one-hot
    typedef enum logic [3:0] {
        ST_CLR  = 4'b0001,
        ST_HIT  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_SUM  = 4'b1000
    } state_t;

    // Commands to the tally unit
    typedef struct packed {
        logic clr;
        logic step;
    } tally_ctl_t;

    // Per-event tallies
    typedef struct packed {
        logic [TALLY_W-1:0] n_zero;
        logic [TALLY_W-1:0] n_one;
        logic [TALLY_W-1:0] n_two;
        logic [TALLY_W-1:0] n_more;
        logic [EMIT_W-1:0]  emitted;
        logic               truncated;
    } tally_t;

endpackage

### rtl/core/moc_ram.sv
// Counter store: one write port and one registered read port.
// Depends on moc_pkg for depth and width.
module moc_ram
    import moc_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [COUNT_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [COUNT_W-1:0] rdata
);

    logic [COUNT_W-1:0] mem [TOTAL_MODULES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/moc_tally.sv
// Occupancy tallies for one event scan and the heavy-item cap decision.
// Depends on moc_pkg.
module moc_tally
    import moc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tally_ctl_t         ctl,
    input  logic [COUNT_W-1:0] value,
    output logic               emit,
    output tally_t             tally
);

    tally_t tally_reg;
    tally_t tally_next;
    logic   heavy;

    // Classify the counter under scan
    assign heavy = value > HEAVY_LIMIT;
    assign emit  = heavy && (tally_reg.emitted < EMIT_W'(MAX_HEAVY_ITEMS));

    // Advance the class counters
    always_comb
    begin
        tally_next = tally_reg;
        if (ctl.clr)
        begin
            tally_next = '0;
        end
        else if (ctl.step)
        begin
            if (value == '0)
            begin
                tally_next.n_zero = tally_reg.n_zero + 1'b1;
            end
            else if (value == COUNT_W'(1))
            begin
                tally_next.n_one = tally_reg.n_one + 1'b1;
            end
            else if (!heavy)
            begin
                tally_next.n_two = tally_reg.n_two + 1'b1;
            end
            else
            begin
                tally_next.n_more = tally_reg.n_more + 1'b1;
                if (emit)
                begin
                    tally_next.emitted = tally_reg.emitted + 1'b1;
                end
                else
                begin
                    tally_next.truncated = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
        end
        else
        begin
            tally_reg <= tally_next;
        end
    end

    assign tally = tally_reg;

endmodule

### rtl/core/module_occupancy_classifier.sv
// Module occupancy classifier: per-module hit counting with end-of-event scan.
// Depends on moc_pkg, moc_ram and moc_tally.
//
// Hits enter one beat per cycle during hit intake; each in-range hit is a
// read-modify-write of one counter in a single-port-read memory, with the
// last write forwarded so back-to-back hits to one module count correctly.
// After reset the block zeroes all TOTAL_MODULES (238) counters of the store
// before it takes a beat. A beat with tlast starts a scan that reads and
// clears one counter per cycle, except while a heavy-module beat waits on
// m_axis_tready; input is held off during the scan and the summary.
module module_occupancy_classifier
    import moc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // layer[5:0], module_req[8:6], zero pad
    input  logic        s_axis_tuser,  // has_hit
    input  logic        s_axis_tlast,  // end_of_event
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // module_index[7:0], hit_count[16:8],
                                       // modules_zero[24:17], modules_one[32:25],
                                       // modules_two[40:33], modules_more[48:41],
                                       // truncated[49], zero pad
    output logic        m_axis_tuser,  // kind
    output logic        m_axis_tlast   // last
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [SCAN_W-1:0]  scan_cnt_reg, scan_cnt_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_scan_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;

    logic               lw_valid_reg;
    logic [ADDR_W-1:0]  lw_addr_reg;
    logic [COUNT_W-1:0] lw_data_reg;

    logic               out_valid_reg, out_valid_next;
    logic [55:0]        out_data_reg;
    logic               out_kind_reg;
    logic               out_last_reg;

    logic [LAYER_W-1:0]  in_layer;
    logic [MODREQ_W-1:0] in_mod;
    logic                in_acc;
    logic                hit_ok;
    logic [HIT_W-1:0]    hit_idx;
    logic                hit_issue;
    logic                scan_issue;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [COUNT_W-1:0]  rd_data;
    logic [COUNT_W-1:0]  cur;
    logic                s1_adv;
    logic                out_free;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [COUNT_W-1:0]  wr_data;
    logic                emit;
    tally_ctl_t          tctl;
    tally_t              tally;
    logic                load_heavy;
    logic                load_sum;
    logic [ADDR_W+IDX_W-1:0] idx_ext;
    logic                scan_done;

    // Unpack the input beat
    assign in_layer = s_axis_tdata[5:0];
    assign in_mod   = s_axis_tdata[8:6];
    assign s_axis_tready = (state_reg == ST_HIT);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Check range and form the counter address
    assign hit_ok = s_axis_tuser
                 && ({1'b0, in_layer} < 7'(NUM_LAYERS))
                 && ({2'b0, in_mod} < 5'(MODULES_PER_LAYER));
    assign hit_idx = HIT_W'(in_layer) * HIT_W'(MODULES_PER_LAYER) + HIT_W'(in_mod);
    assign hit_issue = in_acc && hit_ok;

    // Output slot is free when empty or draining this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    // Forward the newest write over the memory read
    assign cur = (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg : rd_data;

    // Stall a scan entry only when it must emit and the slot is busy
    assign s1_adv = !s1_scan_reg || !emit || out_free;

    assign scan_done  = (scan_cnt_reg == SCAN_W'(TOTAL_MODULES));
    assign scan_issue = (state_reg == ST_SCAN) && !scan_done
                     && (!s1_valid_reg || s1_adv);

    // Select the read address
    assign rd_en   = hit_issue || scan_issue;
    assign rd_addr = hit_issue ? hit_idx[ADDR_W-1:0] : scan_cnt_reg[ADDR_W-1:0];

    // Select the write: clearing pass, hit increment or scan clear
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = s1_addr_reg;
        wr_data = '0;
        if (state_reg == ST_CLR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
        end
        else if (s1_valid_reg && s1_adv)
        begin
            wr_en = 1'b1;
            if (!s1_scan_reg)
            begin
                wr_data = (cur == COUNT_MAX) ? cur : cur + 1'b1;
            end
        end
    end

    moc_ram u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign tctl.clr  = in_acc && s_axis_tlast;
    assign tctl.step = s1_valid_reg && s1_scan_reg && s1_adv;

    moc_tally u_tally (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tctl),
        .value (cur),
        .emit  (emit),
        .tally (tally)
    );

    assign load_heavy = tctl.step && emit;
    assign load_sum   = (state_reg == ST_SUM) && out_free;

    // Sequence reset clear, hit intake, scan and summary
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            ST_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(TOTAL_MODULES - 1))
                begin
                    state_next = ST_HIT;
                end
            end
            ST_HIT:
            begin
                if (in_acc && s_axis_tlast)
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (scan_done && !s1_valid_reg)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (load_sum)
                begin
                    state_next = ST_HIT;
                end
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end

    assign s1_valid_next = rd_en || (s1_valid_reg && !s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            clr_cnt_reg  <= '0;
            scan_cnt_reg <= '0;
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            scan_cnt_reg <= scan_cnt_next;
            s1_valid_reg <= s1_valid_next;
            if (wr_en)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    // Track the read stage and the newest write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_scan_reg <= !hit_issue;
            s1_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= wr_data;
        end
    end

    // Hold the output beat until taken
    assign idx_ext = {{IDX_W{1'b0}}, s1_addr_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_heavy || load_sum)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_heavy)
        begin
            out_kind_reg <= KIND_HEAVY;
            out_last_reg <= 1'b0;
            out_data_reg <= {39'd0, cur, idx_ext[IDX_W-1:0]};
        end
        else if (load_sum)
        begin
            out_kind_reg <= KIND_SUMMARY;
            out_last_reg <= 1'b1;
            out_data_reg <= {6'd0, tally.truncated, tally.n_more, tally.n_two,
                             tally.n_one, tally.n_zero, 17'd0};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
